// File: rtl/cumulative_table_search_macros.svh
// Assertion macros for the cumulative table search block.
// Included by the files that carry concurrent assertions; depends on nothing else.
`ifndef CUMULATIVE_TABLE_SEARCH_MACROS_SVH
`define CUMULATIVE_TABLE_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define CTS_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("cumulative_table_search assertion failed");
`define CTS_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("cumulative_table_search assertion failed");
`else
`define CTS_ASSERT_SAME(label, clk, rst, cond, expr)
`define CTS_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

// File: rtl/cts_pkg.sv
// Shared constants and types of the cumulative table search block.
// Used by cts_table and cumulative_table_search; depends on nothing else.
package cts_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = ADDR_W + 1;
   localparam int KEY_W       = 16;
   localparam int VALUE_W     = 32;
   localparam int DATA_W      = 32;
   localparam int PADDR_W     = 3;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic REG_ENTRIES_IN_USE = 1'b0;

   typedef struct packed {
      logic               op;
      logic [ADDR_W-1:0]  entry_index;
      logic [KEY_W-1:0]   entry_key;
      logic [VALUE_W-1:0] entry_value;
      logic [VALUE_W-1:0] query_value;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [KEY_W-1:0] result_key;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  index;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } tbl_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] mid;
      logic [ADDR_W-1:0] prev;
   } tbl_rd_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key_mid;
      logic [VALUE_W-1:0] value_mid;
      logic [VALUE_W-1:0] value_prev;
   } tbl_data_type;

endpackage

// File: rtl/cts_table.sv
// Key and cumulative value memories of the search block, with registered reads.
// Depends on cts_pkg for widths and the access structs.
module cts_table (
   input  logic                  clock,
   input  cts_pkg::tbl_wr_type   wr,
   input  cts_pkg::tbl_rd_type   rd,
   output cts_pkg::tbl_data_type rd_data
);

   logic [cts_pkg::KEY_W-1:0]   key_mem   [cts_pkg::TABLE_DEPTH];
   logic [cts_pkg::VALUE_W-1:0] value_mem [cts_pkg::TABLE_DEPTH];
   cts_pkg::tbl_data_type       rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.index]   <= wr.key;
         value_mem[wr.index] <= wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff.key_mid    <= key_mem[rd.mid];
         rd_data_ff.value_mid  <= value_mem[rd.mid];
         rd_data_ff.value_prev <= value_mem[rd.prev];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cumulative_table_search.sv
// Top level of the cumulative table search block: handshake, register port and search control.
// Depends on cts_pkg, cts_table and cumulative_table_search_macros.svh.
//
// A write item stores one key and cumulative value and gives no result.
// A search item binary-searches the first entries_in_use entries (saturated at the table
// depth). Its result is registered when a probe hits, or when the search range runs empty
// on a miss. A search of 256 entries makes at most 9 probes. Each probe is a read of the
// memories in S_PROBE, reading the middle entry and its predecessor through two value read
// ports, and a compare in S_CMP. The next item is accepted once the search has handed its
// result to the output register, which holds it until it is taken.
`include "cumulative_table_search_macros.svh"

module cumulative_table_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cts_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cts_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cts_pkg::PADDR_W-1:0]   paddr,
   input  logic [cts_pkg::DATA_W-1:0]    pwdata,
   output logic [cts_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_CMP,
      S_FINISH
   } state_type;

   state_type                     state_ff;
   logic [cts_pkg::COUNT_W-1:0]   entries_ff;
   logic [cts_pkg::COUNT_W-1:0]   lo_ff;
   logic [cts_pkg::COUNT_W-1:0]   end_ff;
   logic [cts_pkg::ADDR_W-1:0]    mid_ff;
   logic                          mid_zero_ff;
   logic [cts_pkg::VALUE_W-1:0]   query_ff;
   logic                          found_ff;
   logic [cts_pkg::KEY_W-1:0]     key_ff;
   logic                          rsp_valid_ff;
   cts_pkg::rsp_type              rsp_ff;

   logic [cts_pkg::COUNT_W-1:0]   count_sat;
   logic [cts_pkg::COUNT_W:0]     mid_sum;
   logic [cts_pkg::ADDR_W-1:0]    mid_calc;
   logic                          range_open;
   logic                          at_or_below;
   logic                          above_prev;
   logic                          hit;
   logic                          out_free;
   logic                          req_fire;
   logic                          csr_write;
   cts_pkg::tbl_wr_type           wr;
   cts_pkg::tbl_rd_type           rd;
   cts_pkg::tbl_data_type         rd_data;

   cts_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   assign count_sat = (entries_ff > cts_pkg::COUNT_W'(cts_pkg::TABLE_DEPTH))
                    ? cts_pkg::COUNT_W'(cts_pkg::TABLE_DEPTH) : entries_ff;
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, end_ff} - (cts_pkg::COUNT_W+1)'(1);
   assign mid_calc   = mid_sum[cts_pkg::ADDR_W:1];
   assign range_open = lo_ff < end_ff;

   assign at_or_below = query_ff <= rd_data.value_mid;
   assign above_prev  = mid_zero_ff || (query_ff > rd_data.value_prev);
   assign hit         = at_or_below && above_prev;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      wr.en    = req_fire && (req_data.op == cts_pkg::OP_WRITE);
      wr.index = req_data.entry_index;
      wr.key   = req_data.entry_key;
      wr.value = req_data.entry_value;
      rd.en    = (state_ff == S_PROBE) && range_open;
      rd.mid   = mid_calc;
      rd.prev  = mid_calc - cts_pkg::ADDR_W'(1);
   end

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == cts_pkg::REG_ENTRIES_IN_USE)
                    ? cts_pkg::DATA_W'(entries_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else if (csr_write && (paddr[2] == cts_pkg::REG_ENTRIES_IN_USE)) begin
         entries_ff <= pwdata[cts_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && (req_data.op == cts_pkg::OP_SEARCH)) begin
                  lo_ff    <= '0;
                  end_ff   <= count_sat;
                  query_ff <= req_data.query_value;
                  state_ff <= S_PROBE;
               end
            end
            S_PROBE: begin
               if (range_open) begin
                  mid_ff      <= mid_calc;
                  mid_zero_ff <= (mid_calc == '0);
                  state_ff    <= S_CMP;
               end else begin
                  found_ff <= 1'b0;
                  key_ff   <= '0;
                  state_ff <= S_FINISH;
               end
            end
            S_CMP: begin
               if (hit) begin
                  found_ff <= 1'b1;
                  key_ff   <= rd_data.key_mid;
                  state_ff <= S_FINISH;
               end else begin
                  if (!at_or_below) begin
                     lo_ff <= {1'b0, mid_ff} + cts_pkg::COUNT_W'(1);
                  end else begin
                     end_ff <= {1'b0, mid_ff};
                  end
                  state_ff <= S_PROBE;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_ff.found      <= found_ff;
                  rsp_ff.result_key <= key_ff;
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CTS_ASSERT_SAME(a_probe_in_range, clock, reset, state_ff == S_CMP, (lo_ff <= {1'b0, mid_ff}) && ({1'b0, mid_ff} < end_ff))
   `CTS_ASSERT_SAME(a_end_bounded, clock, reset, state_ff != S_IDLE, end_ff <= cts_pkg::COUNT_W'(cts_pkg::TABLE_DEPTH))
   `CTS_ASSERT_SAME(a_miss_key_zero, clock, reset, rsp_valid_ff && !rsp_ff.found, rsp_ff.result_key == '0)
   `CTS_ASSERT_NEXT(a_finish_loads, clock, reset, (state_ff == S_FINISH) && out_free, rsp_valid_ff && (state_ff == S_IDLE))

endmodule
